@@ rtl/core/mnl_pkg.sv @@
// Package for the motion night light controller.
// Types, codes and constants shared by the core modules, checker and testbench.
// No dependencies.
`default_nettype none

package mnl_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_POL  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DARK_THRESH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_DELAY   = 2'd3;

    // Register reset values
    localparam logic        RST_ENABLE      = 1'b1;
    localparam logic        RST_MOTION_POL  = 1'b1;
    localparam logic [15:0] RST_DARK_THRESH = 16'd6;
    localparam logic [11:0] RST_OFF_DELAY   = 12'd120;

    localparam int unsigned TICKS_PER_SEC_DEFAULT = 10;
    localparam int unsigned DELAY_MAX_SEC         = 3600;
    localparam logic [15:0] WAIT_MAX              = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_LAMP   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE        = 2'd0,
        CMD_ON          = 2'd1,
        CMD_OFF_RESTORE = 2'd2,
        CMD_RESTORE     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_DISABLED = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_AUTO_ON  = 3'd2,
        MODE_WAIT_OFF = 3'd3,
        MODE_MANUAL   = 3'd4
    } mode_t;

    typedef struct packed {
        logic        enable;
        logic        motion_active_high;
        logic [15:0] dark_threshold_raw;
        logic [11:0] off_delay_sec;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] off_wait_ticks;
        logic [15:0] last_light_raw;
        logic        light_valid;
        logic        lamp_was_on;
        logic        own_change_pending;
        logic        restore_pending;
        logic        motion_latched;
    } state_t;

    typedef struct packed {
        op_t         op;
        logic        motion_level;
        logic [15:0] light_sample;
        logic        sample_ok;
        logic        light_on;
    } item_t;

    typedef struct packed {
        cmd_t        command;
        logic [2:0]  mode_now;
        logic        is_dark;
        logic        motion_seen;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/mnl_item_if.sv @@
// Request channel into the night light controller: valid/ready plus item fields.
// Depends on nothing.
`default_nettype none

interface mnl_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic        motion_level;
    logic [15:0] light_sample;
    logic        sample_ok;
    logic        light_on;

    modport source (output valid, op, motion_level, light_sample, sample_ok, light_on,
                    input ready);
    modport sink (input valid, op, motion_level, light_sample, sample_ok, light_on,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/mnl_result_if.sv @@
// Result channel out of the night light controller: valid/ready plus result fields.
// Depends on nothing.
`default_nettype none

interface mnl_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] mode_now;
    logic       is_dark;
    logic       motion_seen;

    modport source (output valid, command, mode_now, is_dark, motion_seen, input ready);
    modport sink (input valid, command, mode_now, is_dark, motion_seen, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mnl_cfg_regs.sv @@
// Configuration register file of the night light controller.
// Depends on mnl_pkg.
`default_nettype none

module mnl_cfg_regs
    import mnl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_ENABLE:      cfg_next.enable             = wr_data[0];
                CFG_MOTION_POL:  cfg_next.motion_active_high = wr_data[0];
                CFG_DARK_THRESH: cfg_next.dark_threshold_raw = wr_data[15:0];
                CFG_OFF_DELAY:   cfg_next.off_delay_sec      = wr_data[11:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= RST_ENABLE;
            cfg_reg.motion_active_high <= RST_MOTION_POL;
            cfg_reg.dark_threshold_raw <= RST_DARK_THRESH;
            cfg_reg.off_delay_sec      <= RST_OFF_DELAY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/mnl_step.sv @@
// Per-request update of the controller: next state and result from current state.
// Depends on mnl_pkg.
`default_nettype none

module mnl_step
    import mnl_pkg::*;
#(
    parameter int unsigned TICKS_PER_SEC = TICKS_PER_SEC_DEFAULT
)
(
    input  wire cfg_t   cfg,
    input  wire state_t st,
    input  wire item_t  itm,
    output state_t      st_next,
    output res_t        res
);

    localparam int unsigned ProdW = $clog2(DELAY_MAX_SEC * TICKS_PER_SEC + 1);

    logic [11:0]      delay_clamped;
    logic [ProdW-1:0] delay_ticks;
    logic [15:0]      off_limit;
    logic             motion_read;
    logic             timing;
    logic             ignore;
    cmd_t             cmd;

    function automatic state_t enter_mode(state_t s, mode_t m);
        state_t r;
        r = s;
        if (m != MODE_WAIT_OFF || s.mode != MODE_WAIT_OFF)
            r.off_wait_ticks = '0;
        r.mode = m;
        return r;
    endfunction

    function automatic logic dark_now(state_t s, logic [15:0] thr);
        return s.light_valid && (s.last_light_raw < thr);
    endfunction

    assign delay_clamped = (cfg.off_delay_sec > 12'(DELAY_MAX_SEC)) ?
                           12'(DELAY_MAX_SEC) : cfg.off_delay_sec;
    assign delay_ticks   = ProdW'(delay_clamped) * ProdW'(TICKS_PER_SEC);
    assign off_limit     = (32'(delay_ticks) > 32'(WAIT_MAX)) ? WAIT_MAX : 16'(delay_ticks);

    // motion after polarity correction
    assign motion_read = cfg.motion_active_high ? itm.motion_level : ~itm.motion_level;

    always_comb
    begin
        st_next = st;
        cmd     = CMD_NONE;
        timing  = 1'b0;
        ignore  = 1'b0;
        if (itm.op == OP_TICK || itm.op == OP_SAMPLE)
        begin
            if (st_next.restore_pending)
            begin
                st_next.restore_pending    = 1'b0;
                st_next.own_change_pending = 1'b1;
                st_next.lamp_was_on        = 1'b0;
                cmd                        = CMD_RESTORE;
            end
            if (!cfg.enable)
            begin
                st_next = enter_mode(st_next, MODE_DISABLED);
            end
            else
            begin
                if (st_next.mode == MODE_DISABLED)
                    st_next = enter_mode(st_next, MODE_IDLE);
                if (itm.op == OP_SAMPLE)
                begin
                    if (itm.sample_ok)
                    begin
                        st_next.last_light_raw = itm.light_sample;
                        st_next.light_valid    = 1'b1;
                    end
                    else
                    begin
                        st_next.light_valid = 1'b0;
                    end
                end
                else
                begin
                    st_next.motion_latched = motion_read;
                    unique case (st_next.mode)
                        MODE_IDLE:
                        begin
                            if (motion_read && dark_now(st_next, cfg.dark_threshold_raw)
                                && !itm.light_on)
                            begin
                                st_next.own_change_pending = 1'b1;
                                st_next = enter_mode(st_next, MODE_AUTO_ON);
                                cmd = CMD_ON;
                            end
                        end
                        MODE_AUTO_ON:
                        begin
                            if (!motion_read)
                            begin
                                st_next = enter_mode(st_next, MODE_WAIT_OFF);
                                timing  = 1'b1;
                            end
                        end
                        MODE_WAIT_OFF:
                        begin
                            if (motion_read)
                            begin
                                st_next = enter_mode(st_next, MODE_AUTO_ON);
                            end
                            else
                            begin
                                if (st_next.off_wait_ticks != WAIT_MAX)
                                    st_next.off_wait_ticks = st_next.off_wait_ticks + 16'd1;
                                timing = 1'b1;
                            end
                        end
                        MODE_MANUAL:
                        begin
                            if (!motion_read)
                                st_next = enter_mode(st_next, MODE_IDLE);
                        end
                        default:
                        begin
                        end
                    endcase
                    if (timing && st_next.off_wait_ticks >= off_limit)
                    begin
                        st_next.own_change_pending = 1'b1;
                        st_next = enter_mode(st_next, MODE_IDLE);
                        cmd = CMD_OFF_RESTORE;
                    end
                end
            end
        end
        else if (itm.op == OP_LAMP)
        begin
            ignore = st_next.own_change_pending;
            st_next.own_change_pending = 1'b0;
            // user switched off a lamp that was on, and not at our request
            if (!ignore && st_next.lamp_was_on && !itm.light_on)
            begin
                if (cfg.enable)
                    st_next.motion_latched = motion_read;
                if (st_next.mode == MODE_AUTO_ON || st_next.mode == MODE_WAIT_OFF)
                begin
                    st_next = enter_mode(st_next, MODE_MANUAL);
                    st_next.restore_pending = 1'b1;
                end
                else if (cfg.enable && st_next.mode == MODE_IDLE && st_next.motion_latched)
                begin
                    st_next = enter_mode(st_next, MODE_MANUAL);
                end
            end
            st_next.lamp_was_on = itm.light_on;
        end
    end

    assign res.command     = cmd;
    assign res.mode_now    = st_next.mode;
    assign res.is_dark     = dark_now(st_next, cfg.dark_threshold_raw);
    assign res.motion_seen = st_next.motion_latched;

endmodule

`default_nettype wire

@@ rtl/core/motion_night_light_controller.sv @@
// Motion night light controller. A request passes an input register, then a result
// register. Throughput: one request per cycle while the result channel is not
// stalled; the combinational state update in mnl_step sets this.
// Reset: mode idle, all flags, counters and the light reading cleared, registers at
// their defaults (enable 1, polarity 1, threshold 6, off delay 120 s).
// Depends on mnl_pkg, mnl_item_if, mnl_result_if, mnl_cfg_regs, mnl_step.
`default_nettype none

module motion_night_light_controller
    import mnl_pkg::*;
#(
    parameter int unsigned TICKS_PER_SEC = TICKS_PER_SEC_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    mnl_item_if.sink                    item,
    mnl_result_if.source                result,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t   cfg;
    state_t state_reg;
    state_t state_next;
    item_t  item_reg;
    logic   item_valid_reg;
    res_t   res_reg;
    res_t   res_next;
    logic   res_valid_reg;
    logic   out_adv;
    logic   in_take;
    logic   in_load;

    mnl_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    mnl_step #(
        .TICKS_PER_SEC (TICKS_PER_SEC)
    ) u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .itm     (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign out_adv    = !res_valid_reg || result.ready;
    assign in_take    = item_valid_reg && out_adv;
    assign item.ready = !item_valid_reg || in_take;
    assign in_load    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg.mode               <= MODE_IDLE;
            state_reg.off_wait_ticks     <= '0;
            state_reg.last_light_raw     <= '0;
            state_reg.light_valid        <= 1'b0;
            state_reg.lamp_was_on        <= 1'b0;
            state_reg.own_change_pending <= 1'b0;
            state_reg.restore_pending    <= 1'b0;
            state_reg.motion_latched     <= 1'b0;
        end
        else
        begin
            if (in_load)
                item_valid_reg <= 1'b1;
            else if (in_take)
                item_valid_reg <= 1'b0;
            if (out_adv)
                res_valid_reg <= item_valid_reg;
            if (in_take)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            item_reg.op           <= op_t'(item.op);
            item_reg.motion_level <= item.motion_level;
            item_reg.light_sample <= item.light_sample;
            item_reg.sample_ok    <= item.sample_ok;
            item_reg.light_on     <= item.light_on;
        end
        if (in_take)
            res_reg <= res_next;
    end

    assign result.valid       = res_valid_reg;
    assign result.command     = res_reg.command;
    assign result.mode_now    = res_reg.mode_now;
    assign result.is_dark     = res_reg.is_dark;
    assign result.motion_seen = res_reg.motion_seen;

endmodule

`default_nettype wire

@@ rtl/core/mnl_checker.sv @@
// Port-level checks for the motion night light controller, bound to the top level.
// Depends on mnl_pkg and motion_night_light_controller.
`default_nettype none

module mnl_checker
    import mnl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] command,
    input wire logic [2:0] mode_now
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(command) && $stable(mode_now))
        else $error("result changed while stalled");

    a_on_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && command == CMD_ON |-> mode_now == MODE_AUTO_ON)
        else $error("switch on without auto on mode");

    a_off_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && command == CMD_OFF_RESTORE |-> mode_now == MODE_IDLE)
        else $error("switch off without return to idle");

    // disabled mode can only finish a pending restore
    a_disabled_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode_now == MODE_DISABLED |-> command == CMD_NONE || command == CMD_RESTORE)
        else $error("lamp command while disabled");

endmodule

bind motion_night_light_controller mnl_checker u_mnl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .command   (result.command),
    .mode_now  (result.mode_now)
);

`default_nettype wire

@@ test/tb_motion_night_light_controller.sv @@
// Testbench for motion_night_light_controller: directed and random requests with random
// stalls on both channels, every result checked against a scoreboard predictor.
// Depends on mnl_pkg, mnl_item_if, mnl_result_if and the controller RTL.

module tb_motion_night_light_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import mnl_pkg::*;

    // Predicts the controller's mode, light and flag state, and holds the results still owed.
    class light_scoreboard;
        bit          en;
        bit          pol;
        logic [15:0] thresh;
        logic [11:0] off_delay;
        mode_t       cur_mode;
        logic [15:0] wait_ticks;
        logic [15:0] light_raw;
        bit          light_valid;
        bit          lamp_was_on;
        bit          own_pending;
        bit          restore_pending;
        bit          motion;
        bit          lamp_hint;
        int          errors;
        res_t        expected_q[$];

        function new();
            en              = RST_ENABLE;
            pol             = RST_MOTION_POL;
            thresh          = RST_DARK_THRESH;
            off_delay       = RST_OFF_DELAY;
            cur_mode        = MODE_IDLE;
            wait_ticks      = '0;
            light_raw       = '0;
            light_valid     = 1'b0;
            lamp_was_on     = 1'b0;
            own_pending     = 1'b0;
            restore_pending = 1'b0;
            motion          = 1'b0;
            lamp_hint       = 1'b0;
            errors          = 0;
        endfunction

        function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_ENABLE:      en = data[0];
                CFG_MOTION_POL:  pol = data[0];
                CFG_DARK_THRESH: thresh = data;
                CFG_OFF_DELAY:   off_delay = data[11:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit dark();
            return light_valid && (light_raw < thresh);
        endfunction

        function int unsigned off_limit();
            int unsigned d;
            int unsigned lim;
            d   = (off_delay > DELAY_MAX_SEC) ? DELAY_MAX_SEC : off_delay;
            lim = d * TICKS_PER_SEC_DEFAULT;
            return (lim > 65535) ? 65535 : lim;
        endfunction

        // The wait counter survives only a move from waiting off into waiting off.
        function void set_mode(mode_t m);
            if (!(m == MODE_WAIT_OFF && cur_mode == MODE_WAIT_OFF))
                wait_ticks = '0;
            cur_mode = m;
        endfunction

        function cmd_t advance_tick(bit lamp_on);
            bit timing;
            timing = 1'b0;
            case (cur_mode)
                MODE_IDLE:
                begin
                    if (motion && dark() && !lamp_on)
                    begin
                        own_pending = 1'b1;
                        set_mode(MODE_AUTO_ON);
                        return CMD_ON;
                    end
                    return CMD_NONE;
                end
                MODE_AUTO_ON:
                begin
                    if (motion)
                        return CMD_NONE;
                    set_mode(MODE_WAIT_OFF);
                    timing = 1'b1;
                end
                MODE_WAIT_OFF:
                begin
                    if (motion)
                    begin
                        set_mode(MODE_AUTO_ON);
                        return CMD_NONE;
                    end
                    if (wait_ticks != WAIT_MAX)
                        wait_ticks++;
                    timing = 1'b1;
                end
                MODE_MANUAL:
                begin
                    if (!motion)
                        set_mode(MODE_IDLE);
                    return CMD_NONE;
                end
                default: return CMD_NONE;
            endcase
            if (timing && wait_ticks >= off_limit())
            begin
                own_pending = 1'b1;
                set_mode(MODE_IDLE);
                return CMD_OFF_RESTORE;
            end
            return CMD_NONE;
        endfunction

        function void note_request(item_t it);
            cmd_t cmd;
            cmd_t c;
            bit   ignore;
            res_t r;
            cmd = CMD_NONE;
            if (it.op == OP_TICK || it.op == OP_SAMPLE)
            begin
                if (restore_pending)
                begin
                    restore_pending = 1'b0;
                    own_pending     = 1'b1;
                    lamp_was_on     = 1'b0;
                    cmd             = CMD_RESTORE;
                end
                if (!en)
                    set_mode(MODE_DISABLED);
                else
                begin
                    if (cur_mode == MODE_DISABLED)
                        set_mode(MODE_IDLE);
                    if (it.op == OP_SAMPLE)
                    begin
                        if (it.sample_ok)
                        begin
                            light_raw   = it.light_sample;
                            light_valid = 1'b1;
                        end
                        else
                            light_valid = 1'b0;
                    end
                    else
                    begin
                        motion = (it.motion_level == pol);
                        c = advance_tick(it.light_on);
                        if (c != CMD_NONE)
                            cmd = c;
                    end
                end
            end
            else if (it.op == OP_LAMP)
            begin
                // A report right after our own command is our own doing.
                ignore      = own_pending;
                own_pending = 1'b0;
                if (!ignore && lamp_was_on && !it.light_on)
                begin
                    if (en)
                        motion = (it.motion_level == pol);
                    if (cur_mode == MODE_AUTO_ON || cur_mode == MODE_WAIT_OFF)
                    begin
                        set_mode(MODE_MANUAL);
                        restore_pending = 1'b1;
                    end
                    else if (en && cur_mode == MODE_IDLE && motion)
                        set_mode(MODE_MANUAL);
                end
                lamp_was_on = it.light_on;
            end
            if (cmd == CMD_ON)
                lamp_hint = 1'b1;
            else if (cmd != CMD_NONE)
                lamp_hint = 1'b0;
            r.command     = cmd;
            r.mode_now    = cur_mode;
            r.is_dark     = dark();
            r.motion_seen = motion;
            expected_q.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: command %0d mode_now %0d", got.command, got.mode_now);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.command !== want.command)
            begin
                $error("command: expected %0d, got %0d", want.command, got.command);
                errors++;
            end
            if (got.mode_now !== want.mode_now)
            begin
                $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
                errors++;
            end
            if (got.is_dark !== want.is_dark)
            begin
                $error("is_dark: expected %0d, got %0d", want.is_dark, got.is_dark);
                errors++;
            end
            if (got.motion_seen !== want.motion_seen)
            begin
                $error("motion_seen: expected %0d, got %0d", want.motion_seen, got.motion_seen);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    bit                     no_idle = 1'b0;
    int                     sent = 0;
    int                     tx_burst = 0;
    light_scoreboard        sb;

    mnl_item_if   item_ch();
    mnl_result_if result_ch();

    motion_night_light_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.apply_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high after a request; it only drops when a gap or an idle wait follows.
    task automatic send(input op_t op, input bit lvl, input logic [15:0] smp, input bit ok,
                        input bit lamp);
        int    gap;
        item_t it;
        if (no_idle)
            gap = 0;
        else if (tx_burst > 0)
        begin
            tx_burst--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 24) == 0)
                tx_burst = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.op           <= op;
        item_ch.motion_level <= lvl;
        item_ch.light_sample <= smp;
        item_ch.sample_ok    <= ok;
        item_ch.light_on     <= lamp;
        do
            @(posedge clk);
        while (!item_ch.ready);
        it.op           = op;
        it.motion_level = lvl;
        it.light_sample = smp;
        it.sample_ok    = ok;
        it.light_on     = lamp;
        sb.note_request(it);
        sent++;
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic phase_config(input int p);
        logic [15:0] d;
        cfg_write(CFG_ENABLE, 16'(($urandom & 16'hFFFE) | (p != 5)));
        cfg_write(CFG_MOTION_POL, 16'(($urandom & 16'hFFFE) | rand_bit()));
        case (p % 4)
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            default: d = 16'($urandom_range(1, 16'hFFFF));
        endcase
        cfg_write(CFG_DARK_THRESH, d);
        // upper bits land outside the 12-bit register
        d = (p == 6) ? 16'd4 : 16'($urandom_range(0, 3));
        d[15:12] = 4'($urandom_range(0, 15));
        cfg_write(CFG_OFF_DELAY, d);
    endtask

    // Mostly well-formed: darken, move, go quiet, switch the lamp; some pure noise.
    task automatic random_scenario();
        int          r;
        int          k;
        int          lim;
        logic [15:0] smp;
        bit          act;
        act = sb.pol;
        r   = $urandom_range(0, 99);
        if (r < 15)
        begin
            if (sb.thresh != 0 && rand_bit())
                smp = 16'($urandom_range(0, sb.thresh - 1));
            else
                smp = 16'($urandom);
            send(OP_SAMPLE, rand_bit(), smp, $urandom_range(0, 9) != 0, rand_bit());
        end
        else if (r < 45)
            send(OP_TICK, act, 16'($urandom), rand_bit(),
                 ($urandom_range(0, 4) == 0) ? rand_bit() : sb.lamp_hint);
        else if (r < 70)
        begin
            lim = sb.off_limit();
            if (lim > 40)
                lim = 40;
            k = $urandom_range(1, lim + 3);
            repeat (k) send(OP_TICK, !act, 16'($urandom), rand_bit(), sb.lamp_hint);
        end
        else if (r < 85)
            send(OP_LAMP, rand_bit(), 16'($urandom), rand_bit(),
                 rand_bit() ? sb.lamp_hint : rand_bit());
        else
            send(op_t'($urandom_range(0, 3)), rand_bit(), 16'($urandom),
                 rand_bit(), rand_bit());
    endtask

    initial
    begin : stimulus
        int n0;
        sb = new();
        item_ch.valid        = 1'b0;
        item_ch.op           = '0;
        item_ch.motion_level = 1'b0;
        item_ch.light_sample = '0;
        item_ch.sample_ok    = 1'b0;
        item_ch.light_on     = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_wdata            = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold 6, delay 120 s
        send(OP_TICK, 1, 16'd0, 0, 0);          // motion but no valid reading
        send(OP_SAMPLE, 0, 16'd0, 1, 0);
        send(OP_SAMPLE, 1, 16'hFFFF, 1, 1);
        send(OP_SAMPLE, 0, 16'd5, 0, 0);        // failed read drops the reading
        send(OP_SAMPLE, 0, 16'd5, 1, 0);
        send(OP_TICK, 1, 16'd0, 0, 1);          // lamp already lit
        send(OP_TICK, 1, 16'd0, 0, 0);          // switch on
        send(OP_LAMP, 0, 16'd0, 0, 1);          // our own change
        send(OP_TICK, 0, 16'd0, 0, 1);          // into waiting off
        send(OP_TICK, 1, 16'd0, 0, 1);          // motion again, back to auto on
        send(OP_LAMP, 1, 16'd0, 0, 0);          // user switches off: override
        send(OP_SAMPLE, 1, 16'd2, 1, 0);        // restore goes out here
        send(OP_LAMP, 1, 16'd0, 0, 0);
        send(OP_TICK, 0, 16'd0, 0, 0);          // override ends without motion
        send(OP_UNUSED, 1, 16'hFFFF, 1, 1);
        wait_idle();
        cfg_write(CFG_OFF_DELAY, 16'd0);
        cfg_write(CFG_MOTION_POL, 16'd0);
        send(OP_TICK, 0, 16'd0, 0, 0);          // active-low motion, switch on
        send(OP_TICK, 1, 16'd0, 0, 1);          // zero delay: off on the entering tick
        send(OP_LAMP, 1, 16'd0, 0, 1);
        send(OP_LAMP, 0, 16'd0, 0, 0);          // user off in idle with motion
        send(OP_TICK, 1, 16'd0, 0, 0);
        send(OP_TICK, 0, 16'd0, 0, 0);
        send(OP_LAMP, 0, 16'd0, 0, 1);
        wait_idle();
        cfg_write(CFG_ENABLE, 16'd0);
        cfg_write(CFG_DARK_THRESH, 16'hFFFF);
        cfg_write(CFG_OFF_DELAY, 16'hFFFF);
        send(OP_LAMP, 1, 16'd0, 0, 0);          // owned lamp switched off while disabled
        send(OP_TICK, 1, 16'd0, 0, 0);
        send(OP_SAMPLE, 0, 16'd9, 1, 0);        // sample ignored while disabled

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            phase_config(p);
            n0 = sent;
            while (sent - n0 < 210)
                random_scenario();
        end

        // Back-to-back ticks through a whole 8 s off delay, i.e. 80 ticks in waiting off.
        wait_idle();
        cfg_write(CFG_ENABLE, 16'd1);
        cfg_write(CFG_MOTION_POL, 16'd1);
        cfg_write(CFG_DARK_THRESH, 16'd6);
        cfg_write(CFG_OFF_DELAY, 16'd8);
        no_idle = 1'b1;
        send(OP_SAMPLE, 0, 16'd0, 1, 0);
        send(OP_TICK, 1, 16'd0, 0, 0);
        send(OP_LAMP, 0, 16'd0, 0, 1);
        repeat (82) send(OP_TICK, 0, 16'($urandom), rand_bit(), rand_bit());
        no_idle = 1'b0;

        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : receiver
        int   gap;
        int   rx_burst;
        int   results_seen;
        res_t got;
        rx_burst        = 0;
        results_seen    = 0;
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // one long hold-off lets the controller back up into the request side
            if (results_seen % 5000 == 400)
                gap = 300;
            else if (no_idle)
                gap = 0;
            else if (rx_burst > 0)
            begin
                rx_burst--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 11);
                if ($urandom_range(0, 24) == 0)
                    rx_burst = $urandom_range(10, 40);
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
            got.command     = cmd_t'(result_ch.command);
            got.mode_now    = result_ch.mode_now;
            got.is_dark     = result_ch.is_dark;
            got.motion_seen = result_ch.motion_seen;
            sb.check_result(got);
            results_seen++;
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mnl_pkg.sv
rtl/core/mnl_item_if.sv
rtl/core/mnl_result_if.sv
rtl/core/mnl_cfg_regs.sv
rtl/core/mnl_step.sv
rtl/core/motion_night_light_controller.sv
rtl/core/mnl_checker.sv
test/tb_motion_night_light_controller.sv
